### hw/rtl/itdt_pkg.sv
// Shared types, constants and helpers for the integer to decimal text unit.
package itdt_pkg;

  localparam int DFLT_VALUE_WIDTH = 32;
  localparam int IN_W             = 32;
  localparam int CHAR_W           = 8;
  // magnitude bits taken per conversion cycle
  localparam int BITS_PER_STEP    = 4;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

  typedef struct packed {
    logic load;
    logic conv;
    logic find;
    logic emit_sign;
    logic emit_digit;
  } itdt_cmd_t;

  typedef struct packed {
    logic missing;
    logic neg;
    logic conv_done;
    logic digit_last;
    logic out_free;
  } itdt_sts_t;

  // decimal digits needed for magnitudes up to 2^(width-1)
  function automatic int itdt_digits(input int width);
    logic [64:0] v;
    int          n;
    v = 65'd1 << (width - 1);
    n = 0;
    for (int i = 0; i < 24; i++) begin
      if (v != '0) begin
        v = v / 10;
        n++;
      end
    end
    return n;
  endfunction

endpackage

### hw/rtl/itdt_ctrl.sv
// Sequencer for load, conversion, leading digit search and character output.
module itdt_ctrl
  import itdt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  input  itdt_sts_t sts,
  output itdt_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_FIND,
    S_SIGN,
    S_DIGIT
  } state_t;

  state_t state;
  state_t state_next;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load = 1'b1;
          // missing marker produces no words
          if (!sts.missing) state_next = S_CONV;
        end
      end
      S_CONV: begin
        cmd.conv = 1'b1;
        if (sts.conv_done) state_next = S_FIND;
      end
      S_FIND: begin
        cmd.find   = 1'b1;
        state_next = sts.neg ? S_SIGN : S_DIGIT;
      end
      S_SIGN: begin
        if (sts.out_free) begin
          cmd.emit_sign = 1'b1;
          state_next    = S_DIGIT;
        end
      end
      S_DIGIT: begin
        if (sts.out_free) begin
          cmd.emit_digit = 1'b1;
          if (sts.digit_last) state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_emit_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_sign || cmd.emit_digit) |-> sts.out_free)
    else $error("character issued with output register full");

  a_conv_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_CONV && !sts.conv_done) |=> state == S_CONV)
    else $error("conversion left early");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_digit && sts.digit_last) |=> state == S_IDLE)
    else $error("no return to idle after final digit");

endmodule

### hw/rtl/itdt_dpath.sv
// Magnitude, shift-add-3 BCD converter, digit index and output register.
module itdt_dpath
  import itdt_pkg::*;
#(
  parameter int VALUE_WIDTH = DFLT_VALUE_WIDTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [IN_W-1:0]   s_tdata,
  input  itdt_cmd_t         cmd,
  output itdt_sts_t         sts,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [CHAR_W-1:0] m_tdata,
  output logic              m_tlast
);

  localparam int MAG_W = VALUE_WIDTH - 1;
  localparam int NDIG  = itdt_digits(VALUE_WIDTH);
  localparam int BCD_W = 4 * NDIG;
  localparam int NSTEP = (MAG_W + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int SH_W  = NSTEP * BITS_PER_STEP;
  localparam int CNT_W = (NSTEP > 1) ? $clog2(NSTEP) : 1;
  localparam int IDX_W = (NDIG > 1) ? $clog2(NDIG) : 1;
  localparam int EXT_W = (VALUE_WIDTH > IN_W) ? VALUE_WIDTH : IN_W;

  logic [EXT_W-1:0]       ext;
  logic [VALUE_WIDTH-1:0] raw;
  logic [VALUE_WIDTH-1:0] raw_neg;
  logic [MAG_W-1:0]       mag_in;

  logic [SH_W-1:0]  sh;
  logic [BCD_W-1:0] bcd;
  logic [CNT_W-1:0] cnt;
  logic             neg;
  logic [IDX_W-1:0] dig_idx;
  logic [IDX_W-1:0] msd_idx;
  logic [3:0]       cur_digit;

  logic [BCD_W-1:0] bcd_w [BITS_PER_STEP+1];
  logic [BCD_W-1:0] adj_w [BITS_PER_STEP];
  logic [SH_W-1:0]  sh_w  [BITS_PER_STEP+1];

  assign ext     = EXT_W'(s_tdata);
  assign raw     = ext[VALUE_WIDTH-1:0];
  assign raw_neg = ~raw + 1'b1;
  assign mag_in  = raw[VALUE_WIDTH-1] ? raw_neg[MAG_W-1:0] : raw[MAG_W-1:0];

  // shift-add-3, BITS_PER_STEP bits per cycle
  always_comb begin
    bcd_w[0] = bcd;
    sh_w[0]  = sh;
    for (int j = 0; j < BITS_PER_STEP; j++) begin
      adj_w[j] = bcd_w[j];
      for (int d = 0; d < NDIG; d++) begin
        if (adj_w[j][4*d +: 4] >= 4'd5) adj_w[j][4*d +: 4] = adj_w[j][4*d +: 4] + 4'd3;
      end
      bcd_w[j+1] = {adj_w[j][BCD_W-2:0], sh_w[j][SH_W-1]};
      sh_w[j+1]  = sh_w[j] << 1;
    end
  end

  // highest nonzero digit; zero value leaves index 0
  always_comb begin
    msd_idx = '0;
    for (int i = 0; i < NDIG; i++) begin
      if (bcd[4*i +: 4] != 4'd0) msd_idx = IDX_W'(i);
    end
  end

  assign cur_digit = bcd[4*dig_idx +: 4];

  always_comb begin
    sts            = '0;
    sts.missing    = (raw == {1'b1, {MAG_W{1'b0}}});
    sts.neg        = neg;
    sts.conv_done  = (cnt == CNT_W'(NSTEP - 1));
    sts.digit_last = (dig_idx == '0);
    sts.out_free   = !m_tvalid || m_tready;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sh  <= SH_W'(mag_in);
      bcd <= '0;
      cnt <= '0;
      neg <= raw[VALUE_WIDTH-1];
    end else if (cmd.conv) begin
      sh  <= sh_w[BITS_PER_STEP];
      bcd <= bcd_w[BITS_PER_STEP];
      cnt <= cnt + 1'b1;
    end
    if (cmd.find) begin
      dig_idx <= msd_idx;
    end else if (cmd.emit_digit) begin
      dig_idx <= dig_idx - 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit_sign || cmd.emit_digit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (cmd.emit_sign) begin
      m_tdata <= CH_MINUS;
      m_tlast <= 1'b0;
    end else if (cmd.emit_digit) begin
      m_tdata <= CH_ZERO + {4'd0, cur_digit};
      m_tlast <= (dig_idx == '0);
    end
  end

  a_msd_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.find |=> (dig_idx == '0 || cur_digit != 4'd0))
    else $error("leading digit search landed on a zero");

  a_last_mark: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_digit |=> (m_tvalid && m_tlast == $past(dig_idx == '0)))
    else $error("last flag does not match final digit");

endmodule

### hw/rtl/int32_to_decimal_text_unit.sv
// Top level: signed integer to decimal ASCII text, one character per word.
//
//  channel   dir  fields (lsb up)              notes
//  s_*       in   tdata[31:0] value            signed; most negative = missing
//  m_*       out  tdata[7:0] out_char, tlast   '-' or '0'..'9'; tlast on final char
//
// An item is taken only when the unit is idle. It then passes through the
// BCD converter, the leading digit search and the character output, which
// emits a '-' for a negative value and then the digits, most significant
// first; a missing value produces no characters.
// Output stalls hold the sequencer in place. rst is synchronous and clears
// the sequencer and the output valid.
module int32_to_decimal_text_unit
  import itdt_pkg::*;
#(
  parameter int VALUE_WIDTH = DFLT_VALUE_WIDTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [IN_W-1:0]   s_tdata,   // [31:0] value
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [CHAR_W-1:0] m_tdata,   // [7:0] out_char
  output logic              m_tlast
);

  itdt_cmd_t cmd;
  itdt_sts_t sts;

  itdt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  itdt_dpath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .cmd      (cmd),
    .sts      (sts),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
